@@ sv/cfet_pkg.sv @@
// ----------------------------------------------------------------------------
// cfet_pkg: shared types and constants for the free-extent table
// Extent entry layout, opcode and status codes, sequencer states.
// ----------------------------------------------------------------------------
package cfet_pkg;

    localparam int MAX_EXTENTS = 64;
    localparam int IDX_W       = $clog2(MAX_EXTENTS);
    localparam int CNT_W       = $clog2(MAX_EXTENTS + 1);
    localparam int ADDR_W      = 32;
    localparam int CFG_IDX_W   = 1;

    typedef logic [ADDR_W-1:0] t_addr;

    typedef struct packed {
        t_addr start;
        t_addr len;
    } t_extent;

    typedef enum logic [1:0] {
        OP_ALLOC  = 2'd0,
        OP_FREE   = 2'd1,
        OP_INIT   = 2'd2,
        OP_UNUSED = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_ZERO_LEN  = 3'd1,
        ST_TOO_LARGE = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_OUT_REGION= 3'd4,
        ST_FULL      = 3'd5
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BASE   = 1'd0,
        REG_LENGTH = 1'd1
    } t_cfg_reg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_AL_RD,
        S_AL_CHK,
        S_FR_RD,
        S_FR_CHK,
        S_BK_RD,
        S_BK_CHK,
        S_FW_RD,
        S_FW_CHK,
        S_SH_RD,
        S_SH_WR,
        S_PUT,
        S_LG_RD,
        S_LG_CHK,
        S_DONE
    } t_state;

    // add two lengths, clamp at the top of the address space
    function automatic t_addr sat_add(input t_addr a, input t_addr b);
        logic [ADDR_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[ADDR_W] ? {ADDR_W{1'b1}} : s[ADDR_W-1:0];
    endfunction

    // one-past-the-end address of an extent, one bit wider
    function automatic logic [ADDR_W:0] ext_end(input t_addr start, input t_addr len);
        return {1'b0, start} + {1'b0, len};
    endfunction

endpackage

@@ sv/cfet_req_if.sv @@
// ----------------------------------------------------------------------------
// cfet_req_if: request channel of the free-extent table
// valid/ready handshake with opcode, address and length.
// ----------------------------------------------------------------------------
interface cfet_req_if;
    import cfet_pkg::*;

    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    t_addr       address;
    t_addr       length;

    modport source (output valid, output opcode, output address, output length,
                    input ready);
    modport sink   (input valid, input opcode, input address, input length,
                    output ready);
endinterface

@@ sv/cfet_rsp_if.sv @@
// ----------------------------------------------------------------------------
// cfet_rsp_if: response channel of the free-extent table
// valid/ready handshake with status, extent count and largest extent.
// ----------------------------------------------------------------------------
interface cfet_rsp_if;
    import cfet_pkg::*;

    logic             valid;
    logic             ready;
    logic [2:0]       status;
    logic [CNT_W-1:0] extent_count;
    t_addr            largest_start;
    t_addr            largest_length;

    modport source (output valid, output status, output extent_count,
                    output largest_start, output largest_length, input ready);
    modport sink   (input valid, input status, input extent_count,
                    input largest_start, input largest_length, output ready);
endinterface

@@ sv/coalescing_free_extent_table.sv @@
// ----------------------------------------------------------------------------
// coalescing_free_extent_table: address-ordered free-extent table
// Alloc carves from a named extent, free inserts and coalesces, init resets
// the table to the whole region. Each request returns status, extent count
// and the largest extent.
//
//  channel   dir  handshake      payload
//  i_req     in   valid/ready    opcode, address, length
//  o_rsp     out  valid/ready    status, extent_count, largest_start/length
//  i_cfg_*   in   write enable   register index, 32-bit data
//
// One request at a time; a single table RAM port (one read, one write per
// cycle, registered read) sets the pace. Every table entry touched takes a
// read step and a check or write step: the search, the merge reads, the
// shift and the largest-extent scan all walk the table this way.
// Reset clears the count, state, response valid and config registers; the RAM needs no clearing pass.
// A finished response waits in the output register; the next request is
// taken meanwhile and is held in its last step until the response leaves.
// ----------------------------------------------------------------------------
module coalescing_free_extent_table (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    cfet_req_if.sink                          i_req,
    cfet_rsp_if.source                        o_rsp,
    input  logic                              i_cfg_we,
    input  logic [cfet_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [cfet_pkg::ADDR_W-1:0]       i_cfg_data
);
    import cfet_pkg::*;

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_EXTENTS);
    localparam logic [CNT_W-1:0] ONE     = CNT_W'(1);

    // table RAM
    t_extent           mem [MAX_EXTENTS];
    t_extent           r_rdata;
    logic              w_we;
    logic [IDX_W-1:0]  w_waddr;
    logic [IDX_W-1:0]  w_raddr;
    t_extent           w_wdata;

    // control and datapath registers
    t_state            r_state, n_state;
    t_addr             r_base, r_rlen;
    t_addr             r_addr, n_addr;
    t_addr             r_len, n_len;
    t_status           r_status, n_status;
    logic [CNT_W-1:0]  r_total, n_total;
    logic [CNT_W-1:0]  r_idx, n_idx;
    logic [CNT_W-1:0]  r_n, n_n;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [CNT_W-1:0]  r_src, n_src;
    logic [CNT_W-1:0]  r_dst, n_dst;
    logic              r_up, n_up;
    logic              r_is_free, n_is_free;
    logic              r_tn, n_tn;
    t_extent           r_cur, n_cur;
    t_extent           r_big, n_big;
    logic              r_out_valid, n_out_valid;
    t_status           r_out_status, n_out_status;
    logic [CNT_W-1:0]  r_out_count, n_out_count;
    t_extent           r_out_big, n_out_big;

    // decoded request and shared compare terms
    logic              w_accept;
    logic [ADDR_W:0]   w_reg_end;
    logic [ADDR_W:0]   w_end;
    logic [ADDR_W:0]   w_span;
    logic              w_out_region;
    logic              w_full;
    logic              w_bk_touch;
    logic              w_fw_touch;
    logic              w_out_free;

    // read address one below an index
    function automatic logic [IDX_W-1:0] n_idx_m1(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] d;
        d = v - ONE;
        return d[IDX_W-1:0];
    endfunction

    assign w_accept   = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);

    // region end clamps at the top of the address space
    assign w_reg_end  = {1'b0, r_base} + {1'b0, r_rlen};
    assign w_end      = w_reg_end[ADDR_W] ? {1'b1, {ADDR_W{1'b0}}} : w_reg_end;
    assign w_span     = {1'b1, {ADDR_W{1'b0}}} - {1'b0, r_base};
    assign w_out_region = (i_req.address < r_base) ||
                          (ext_end(i_req.address, i_req.length) > w_end);

    // full only if the block touches neither neighbor
    assign w_full     = (r_total >= MAX_CNT) && (r_n == r_idx) && !r_tn;
    assign w_bk_touch = ext_end(r_rdata.start, r_rdata.len) == {1'b0, r_cur.start};
    assign w_fw_touch = ext_end(r_cur.start, r_cur.len) == {1'b0, r_rdata.start};
    assign w_out_free = !r_out_valid || o_rsp.ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_req.opcode)
                        OP_ALLOC: n_state = (i_req.length == '0) ? S_LG_RD : S_AL_RD;
                        OP_FREE:  n_state = (w_out_region || i_req.length == '0) ?
                                            S_LG_RD : S_FR_RD;
                        default:  n_state = S_LG_RD;
                    endcase
                end
            end
            S_AL_RD:  n_state = (r_idx == r_total) ? S_LG_RD : S_AL_CHK;
            S_AL_CHK: begin
                if (r_rdata.start != r_addr) begin
                    n_state = S_AL_RD;
                end else if (r_rdata.len == r_len) begin
                    n_state = S_SH_RD;
                end else begin
                    n_state = S_LG_RD;
                end
            end
            S_FR_RD:  n_state = (r_idx == r_total) ? S_BK_RD : S_FR_CHK;
            S_FR_CHK: n_state = (r_rdata.start >= r_addr) ? S_BK_RD : S_FR_RD;
            S_BK_RD: begin
                if (r_n != '0) begin
                    n_state = S_BK_CHK;
                end else begin
                    n_state = w_full ? S_LG_RD : S_FW_RD;
                end
            end
            S_BK_CHK: begin
                if (w_bk_touch) begin
                    n_state = S_BK_RD;
                end else begin
                    n_state = w_full ? S_LG_RD : S_FW_RD;
                end
            end
            S_FW_RD:  n_state = (r_idx == r_total) ? S_SH_RD : S_FW_CHK;
            S_FW_CHK: n_state = w_fw_touch ? S_FW_RD : S_SH_RD;
            S_SH_RD: begin
                if (r_cnt != '0) begin
                    n_state = S_SH_WR;
                end else begin
                    n_state = r_is_free ? S_PUT : S_LG_RD;
                end
            end
            S_SH_WR:  n_state = S_SH_RD;
            S_PUT:    n_state = S_LG_RD;
            S_LG_RD:  n_state = (r_idx == r_total) ? S_DONE : S_LG_CHK;
            S_LG_CHK: n_state = S_LG_RD;
            S_DONE:   n_state = w_out_free ? S_IDLE : S_DONE;
            default:  n_state = S_IDLE;
        endcase
    end

    // datapath and RAM control
    always_comb begin
        n_addr       = r_addr;
        n_len        = r_len;
        n_status     = r_status;
        n_total      = r_total;
        n_idx        = r_idx;
        n_n          = r_n;
        n_cnt        = r_cnt;
        n_src        = r_src;
        n_dst        = r_dst;
        n_up         = r_up;
        n_is_free    = r_is_free;
        n_tn         = r_tn;
        n_cur        = r_cur;
        n_big        = r_big;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_status = r_out_status;
        n_out_count  = r_out_count;
        n_out_big    = r_out_big;
        w_we         = 1'b0;
        w_waddr      = '0;
        w_wdata      = r_cur;
        w_raddr      = r_idx[IDX_W-1:0];

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_addr     = i_req.address;
                    n_len      = i_req.length;
                    n_status   = ST_OK;
                    n_idx      = '0;
                    n_cur      = '{start: i_req.address, len: i_req.length};
                    case (i_req.opcode)
                        OP_ALLOC: begin
                            if (i_req.length == '0) n_status = ST_ZERO_LEN;
                        end
                        OP_FREE: begin
                            if (w_out_region) begin
                                n_status = ST_OUT_REGION;
                            end else if (i_req.length == '0) begin
                                n_status = ST_ZERO_LEN;
                            end
                        end
                        OP_INIT: begin
                            // one extent over the whole region
                            n_total = (r_rlen != '0) ? ONE : '0;
                            w_we    = (r_rlen != '0);
                            w_wdata = '{start: r_base,
                                        len: ({1'b0, r_rlen} < w_span) ? r_rlen :
                                             w_span[ADDR_W-1:0]};
                        end
                        default: ;
                    endcase
                end
            end
            // alloc: search by start address
            S_AL_RD: begin
                if (r_idx == r_total) n_status = ST_NOT_FOUND;
            end
            S_AL_CHK: begin
                if (r_rdata.start != r_addr) begin
                    n_idx = r_idx + ONE;
                end else if (r_rdata.len < r_len) begin
                    n_status = ST_TOO_LARGE;
                end else if (r_rdata.len > r_len) begin
                    w_we    = 1'b1;
                    w_waddr = r_idx[IDX_W-1:0];
                    w_wdata = '{start: r_rdata.start + r_len, len: r_rdata.len - r_len};
                end else begin
                    // used up: close the gap
                    n_is_free = 1'b0;
                    n_up      = 1'b0;
                    n_src     = r_idx + ONE;
                    n_dst     = r_idx;
                    n_cnt     = r_total - r_idx - ONE;
                end
            end
            // free: find insert point
            S_FR_RD: begin
                if (r_idx == r_total) begin
                    n_tn = 1'b0;
                    n_n  = r_idx;
                end
            end
            S_FR_CHK: begin
                if (r_rdata.start >= r_addr) begin
                    n_tn = ext_end(r_addr, r_len) == {1'b0, r_rdata.start};
                    n_n  = r_idx;
                end else begin
                    n_idx = r_idx + ONE;
                end
            end
            // merge with lower neighbors
            S_BK_RD: begin
                w_raddr = n_idx_m1(r_n);
                if (r_n == '0 && w_full) n_status = ST_FULL;
            end
            S_BK_CHK: begin
                if (w_bk_touch) begin
                    n_cur = '{start: r_rdata.start, len: sat_add(r_rdata.len, r_cur.len)};
                    n_n   = r_n - ONE;
                end else if (w_full) begin
                    n_status = ST_FULL;
                end
            end
            // merge with upper neighbors, then plan the shift
            S_FW_RD: begin
                if (r_idx == r_total) begin
                    n_is_free = 1'b1;
                    n_cnt     = r_total - r_idx;
                    n_up      = (r_idx == r_n);
                    n_src     = (r_idx == r_n) ? r_total - ONE : r_idx;
                    n_dst     = (r_idx == r_n) ? r_total : r_n + ONE;
                end
            end
            S_FW_CHK: begin
                if (w_fw_touch) begin
                    n_cur.len = sat_add(r_cur.len, r_rdata.len);
                    n_idx     = r_idx + ONE;
                end else begin
                    n_is_free = 1'b1;
                    n_cnt     = r_total - r_idx;
                    n_up      = (r_idx == r_n);
                    n_src     = (r_idx == r_n) ? r_total - ONE : r_idx;
                    n_dst     = (r_idx == r_n) ? r_total : r_n + ONE;
                end
            end
            // move one entry: read it, then write it to its new place
            S_SH_RD: begin
                w_raddr = r_src[IDX_W-1:0];
                if (r_cnt == '0 && !r_is_free) n_total = r_total - ONE;
            end
            S_SH_WR: begin
                w_we    = 1'b1;
                w_waddr = r_dst[IDX_W-1:0];
                w_wdata = r_rdata;
                n_src   = r_up ? r_src - ONE : r_src + ONE;
                n_dst   = r_up ? r_dst - ONE : r_dst + ONE;
                n_cnt   = r_cnt - ONE;
            end
            S_PUT: begin
                w_we    = 1'b1;
                w_waddr = r_n[IDX_W-1:0];
                w_wdata = r_cur;
                n_total = r_total + ONE - (r_idx - r_n);
            end
            // largest extent, lowest address wins ties
            S_LG_RD: ;
            S_LG_CHK: begin
                if (r_rdata.len > r_big.len) n_big = r_rdata;
                n_idx = r_idx + ONE;
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_count  = r_total;
                    n_out_big    = r_big;
                end
            end
            default: ;
        endcase

        // start of the largest-extent scan
        if (n_state == S_LG_RD && r_state != S_LG_CHK) begin
            n_idx = '0;
            n_big = '0;
        end
    end

    // table RAM, registered read
    always_ff @(posedge i_clk) begin
        if (w_we) mem[w_waddr] <= w_wdata;
        r_rdata <= mem[w_raddr];
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
            r_rlen <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_BASE:   r_base <= i_cfg_data;
                REG_LENGTH: r_rlen <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_addr       <= n_addr;
        r_len        <= n_len;
        r_status     <= n_status;
        r_idx        <= n_idx;
        r_n          <= n_n;
        r_cnt        <= n_cnt;
        r_src        <= n_src;
        r_dst        <= n_dst;
        r_up         <= n_up;
        r_is_free    <= n_is_free;
        r_tn         <= n_tn;
        r_cur        <= n_cur;
        r_big        <= n_big;
        r_out_status <= n_out_status;
        r_out_count  <= n_out_count;
        r_out_big    <= n_out_big;
    end

    // response port
    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.status         = r_out_status;
    assign o_rsp.extent_count   = r_out_count;
    assign o_rsp.largest_start  = r_out_big.start;
    assign o_rsp.largest_length = r_out_big.len;

endmodule

@@ sv/cfet_checker.sv @@
// ----------------------------------------------------------------------------
// cfet_checker: port-level checks for the free-extent table
// Response consistency and handshake behavior seen at the top-level ports.
// ----------------------------------------------------------------------------
module cfet_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [2:0]                    status,
    input  logic [cfet_pkg::CNT_W-1:0]    extent_count,
    input  logic [cfet_pkg::ADDR_W-1:0]   largest_start,
    input  logic [cfet_pkg::ADDR_W-1:0]   largest_length
);
    import cfet_pkg::*;

    // count never exceeds the table depth
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> extent_count <= CNT_W'(MAX_EXTENTS))
        else $error("extent count beyond table depth");

    // an empty table reports no largest extent, a held one reports a length
    a_empty_largest: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((extent_count == '0) == (largest_length == '0)) &&
                      (extent_count != '0 || largest_start == '0))
        else $error("largest extent inconsistent with count");

    // status codes stay within the defined set
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= ST_FULL)
        else $error("undefined status code");

    // one request at a time: busy right after taking one
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request taken while busy");

    // a pending response holds until taken
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid && $stable(status) &&
                                      $stable(extent_count) && $stable(largest_length))
        else $error("response dropped or changed while stalled");

endmodule

bind coalescing_free_extent_table cfet_checker u_cfet_checker (
    .clk            (i_clk),
    .rst_n          (i_rst_n),
    .in_valid       (i_req.valid),
    .in_ready       (i_req.ready),
    .out_valid      (o_rsp.valid),
    .out_ready      (o_rsp.ready),
    .status         (o_rsp.status),
    .extent_count   (o_rsp.extent_count),
    .largest_start  (o_rsp.largest_start),
    .largest_length (o_rsp.largest_length)
);

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb: self-checking bench for coalescing_free_extent_table
// Drives alloc/free/init requests over several region settings. A scoreboard
// keeps its own address-ordered extent table, predicts every response and
// compares it field by field. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
    import cfet_pkg::*;

    localparam int CYCLE_LIMIT = 4000000;
    localparam int N_RANDOM    = 1506;

    typedef struct {
        t_status          status;
        logic [CNT_W-1:0] count;
        t_addr            lg_start;
        t_addr            lg_len;
    } t_expect;

    typedef struct {
        t_addr a;
        t_addr l;
    } t_block;

    // reference table and expected responses
    class extent_scoreboard;
        t_extent tbl[$];
        t_addr   base;
        t_addr   rlen;
        t_expect pending[$];
        int      errors;
        int      mismatches;
        int      checked;
        t_status last_st;

        function logic [ADDR_W:0] region_end();
            logic [ADDR_W:0] e;
            e = {1'b0, base} + {1'b0, rlen};
            return (e > {1'b1, {ADDR_W{1'b0}}}) ? {1'b1, {ADDR_W{1'b0}}} : e;
        endfunction

        function logic [ADDR_W:0] tail(int i);
            return {1'b0, tbl[i].start} + {1'b0, tbl[i].len};
        endfunction

        function t_addr clamp_sum(t_addr x, t_addr y);
            logic [ADDR_W:0] s;
            s = {1'b0, x} + {1'b0, y};
            return s[ADDR_W] ? '1 : s[ADDR_W-1:0];
        endfunction

        function void note_request(t_opcode op, t_addr a, t_addr l);
            t_status st;
            t_expect e;
            t_extent x;
            int i;
            int n;
            bit tp;
            bit tn;
            st = ST_OK;
            case (op)
                OP_ALLOC: begin
                    i = 0;
                    while (i < tbl.size() && tbl[i].start != a) i++;
                    if (l == 0) st = ST_ZERO_LEN;
                    else if (i >= tbl.size()) st = ST_NOT_FOUND;
                    else if (tbl[i].len < l) st = ST_TOO_LARGE;
                    else if (tbl[i].len > l) begin
                        tbl[i].start += l;
                        tbl[i].len -= l;
                    end else tbl.delete(i);
                end
                OP_FREE: begin
                    i = 0;
                    while (i < tbl.size() && tbl[i].start < a) i++;
                    tp = (i > 0) && (tail(i-1) == {1'b0, a});
                    tn = (i < tbl.size()) && ({1'b0, a} + {1'b0, l} == {1'b0, tbl[i].start});
                    if (a < base || {1'b0, a} + {1'b0, l} > region_end()) st = ST_OUT_REGION;
                    else if (l == 0) st = ST_ZERO_LEN;
                    else if (tbl.size() >= MAX_EXTENTS && !tp && !tn) st = ST_FULL;
                    else begin
                        x.start = a;
                        x.len = l;
                        tbl.insert(i, x);
                        n = i;
                        // coalesce downward, then upward
                        while (n > 0 && tail(n-1) == {1'b0, tbl[n].start}) begin
                            tbl[n-1].len = clamp_sum(tbl[n-1].len, tbl[n].len);
                            tbl.delete(n);
                            n--;
                        end
                        while (n + 1 < tbl.size() && tail(n) == {1'b0, tbl[n+1].start}) begin
                            tbl[n].len = clamp_sum(tbl[n].len, tbl[n+1].len);
                            tbl.delete(n+1);
                        end
                    end
                end
                OP_INIT: begin
                    tbl.delete();
                    if (region_end() > {1'b0, base}) begin
                        x.start = base;
                        x.len = t_addr'(region_end() - {1'b0, base});
                        if (x.len != 0) tbl.push_back(x);
                    end
                end
                default: ;
            endcase
            e.status = st;
            e.count = CNT_W'(tbl.size());
            e.lg_start = '0;
            e.lg_len = '0;
            foreach (tbl[k]) begin
                if (tbl[k].len > e.lg_len) begin
                    e.lg_len = tbl[k].len;
                    e.lg_start = tbl[k].start;
                end
            end
            pending.push_back(e);
            last_st = st;
        endfunction

        function void check(logic [2:0] st, logic [CNT_W-1:0] cnt, t_addr ls, t_addr ll);
            t_expect e;
            checked++;
            if (pending.size() == 0) begin
                errors++;
                $display("response with nothing outstanding: st=%0d cnt=%0d", st, cnt);
                return;
            end
            e = pending.pop_front();
            if (st !== e.status || cnt !== e.count || ls !== e.lg_start || ll !== e.lg_len) begin
                errors++;
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch #%0d: exp st=%0d cnt=%0d lg=%h/%h got st=%0d cnt=%0d lg=%h/%h",
                             checked, e.status, e.count, e.lg_start, e.lg_len,
                             st, cnt, ls, ll);
            end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [ADDR_W-1:0]    i_cfg_data;

    cfet_req_if req ();
    cfet_rsp_if rsp ();

    coalescing_free_extent_table dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req),
        .o_rsp      (rsp),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    extent_scoreboard sb;
    t_block  held[$];
    int      cycles;
    int      sent;
    int      send_idle;
    int      rsp_stall;
    int      full_seen;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // response side: random stall and checking
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
        if (!i_rst_n) rsp.ready <= 1'b0;
        else rsp.ready <= ($urandom_range(99) >= rsp_stall);
        if (i_rst_n && rsp.valid && rsp.ready) begin
            sb.check(rsp.status, rsp.extent_count, rsp.largest_start, rsp.largest_length);
            if (rsp.status == ST_FULL) full_seen++;
        end
    end

    // idle mix follows progress through the stimulus
    always @(posedge i_clk) begin
        if (sent < 620) begin
            send_idle <= 15;
            rsp_stall <= 53;
        end else if (sent < 1240) begin
            send_idle <= 53;
            rsp_stall <= 15;
        end else begin
            send_idle <= 0;
            rsp_stall <= 0;
        end
    end

    // one request; valid stays high into the next call unless a gap follows
    task automatic send(t_opcode op, t_addr a, t_addr l);
        while ($urandom_range(99) < send_idle) begin
            req.valid <= 1'b0;
            @(posedge i_clk);
        end
        req.valid   <= 1'b1;
        req.opcode  <= op;
        req.address <= a;
        req.length  <= l;
        do @(posedge i_clk); while (!req.ready);
        sb.note_request(op, a, l);
        sent++;
    endtask

    // config writes only with the table idle; the caller drops the enable
    task automatic write_reg(t_cfg_reg idx, t_addr val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        if (idx == REG_BASE) sb.base = val;
        else sb.rlen = val;
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic set_region(t_addr b, t_addr l);
        drain();
        write_reg(REG_BASE, b);
        write_reg(REG_LENGTH, l);
        i_cfg_we <= 1'b0;
        send(OP_INIT, $urandom, $urandom);
        held.delete();
    endtask

    // many one-unit allocs, then release every other one
    task automatic fragment();
        int k;
        for (k = 0; k < 70; k++) begin
            if (sb.tbl.size() == 0 || sb.tbl[0].len < 2) break;
            send(OP_ALLOC, sb.tbl[0].start, 1);
            if (sb.last_st == ST_OK) held.push_back('{sb.tbl[0].start - 1, 1});
        end
        for (k = held.size() - 1; k >= 0; k -= 2) begin
            send(OP_FREE, held[k].a, held[k].l);
            held.delete(k);
        end
    endtask

    // one random request, mostly well-formed against the current table
    task automatic random_item();
        int r;
        int i;
        t_addr a;
        t_addr l;
        t_addr h;
        r = $urandom_range(99);
        if (r < 8 || (r < 55 && sb.tbl.size() == 0)) begin
            send(t_opcode'($urandom_range(3)), $urandom, $urandom);
        end else if (r < 55) begin
            i = $urandom_range(sb.tbl.size() - 1);
            a = sb.tbl[i].start;
            l = sb.tbl[i].len;
            case ($urandom_range(9))
                0: h = l;
                1: h = (l == '1) ? l : l + 1;
                2: h = $urandom_range(1, l);
                default: h = $urandom_range(1, (l < 64) ? l : 64);
            endcase
            send(OP_ALLOC, a, h);
            if (sb.last_st == ST_OK) held.push_back('{a, h});
        end else if (r < 97) begin
            if (held.size() == 0) begin
                send(OP_FREE, sb.base + $urandom_range(255), $urandom_range(16));
            end else begin
                i = $urandom_range(held.size() - 1);
                a = held[i].a;
                l = held[i].l;
                if (l > 1 && $urandom_range(3) == 0) begin
                    h = $urandom_range(1, l - 1);
                    send(OP_FREE, a, h);
                    held[i] = '{a + h, l - h};
                end else begin
                    send(OP_FREE, a, l);
                    held.delete(i);
                end
            end
        end else begin
            send(OP_INIT, $urandom, $urandom);
            held.delete();
        end
    endtask

    initial begin
        t_addr bases[6];
        t_addr lens[6];
        int ph;
        int k;
        sb = new();
        sent = 0;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= REG_BASE;
        i_cfg_data <= '0;
        req.valid <= 1'b0;
        req.opcode <= OP_INIT;
        req.address <= '0;
        req.length <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: registers still at reset, so init yields an empty table
        send(OP_INIT, '0, '0);
        set_region(32'h100, 32'h40);
        send(OP_ALLOC, 32'h100, 0);             // zero length
        send(OP_ALLOC, 32'h123, 1);             // no such extent
        send(OP_ALLOC, 32'h100, 32'h41);        // too large
        send(OP_ALLOC, 32'h100, 32'h10);        // carve low end
        send(OP_ALLOC, 32'h110, 32'h30);        // exact, extent removed
        send(OP_FREE, 32'hFF, 1);               // below base
        send(OP_FREE, 32'h13F, 2);              // past region end
        send(OP_FREE, 32'h120, 0);              // zero length
        send(OP_FREE, 32'h100, 32'h10);
        send(OP_FREE, 32'h120, 32'h10);
        send(OP_FREE, 32'h110, 32'h10);         // merges both sides
        send(OP_FREE, 32'h108, 4);              // overlapping free
        send(OP_ALLOC, 32'h108, 4);
        send(OP_UNUSED, '1, '1);
        send(OP_FREE, '1, '1);
        send(OP_ALLOC, '0, '1);

        // random phases over several region settings, extremes included
        bases = '{32'h1000_0000, 32'h0, 32'hFFFF_F000, 32'hFFFF_FFFF, 32'h0, 32'h8000_0000};
        lens  = '{32'h0001_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0, 32'h100};
        for (ph = 0; ph < 6; ph++) begin
            set_region(bases[ph], lens[ph]);
            if (ph < 3) fragment();
            for (k = 0; k < N_RANDOM / 6; k++) random_item();
        end

        drain();
        $display("%0d requests sent, %0d responses checked over 7 region settings;",
                 sent, sb.checked);
        $display("table-full responses: %0d, mismatches: %0d", full_seen, sb.mismatches);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

@@ coalescing_free_extent_table.f @@
sv/cfet_pkg.sv
sv/cfet_req_if.sv
sv/cfet_rsp_if.sv
sv/coalescing_free_extent_table.sv
sv/cfet_checker.sv
sim/tb.sv
